/* sv/sus_pkg.sv */
// Shared types and constants for the sorted union block.
// Used by sus_cell and by the top level sorted_union_without_duplicates.
`default_nettype none

package sus_pkg;

   // width of one list element
   localparam int VALUE_W = 32;

   // controller states
   typedef enum logic [0:0] {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // controls broadcast from the top level to every cell
   typedef struct packed {
      logic                      insert;  // place ctrl value in sorted order
      logic                      shift;   // move every value one cell toward the head
      logic signed [VALUE_W-1:0] value;   // value being loaded
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* sv/sus_cell.sv */
// One storage cell of the sorted chain: holds one kept value, compares it
// with the broadcast value and takes data from either neighbor.
// Depends on sus_pkg.
`default_nettype none

module sus_cell (
   input  wire logic                               clock,
   input  wire sus_pkg::cell_ctrl_type             ctrl,
   input  wire logic                               occupied,
   input  wire logic                               tail,
   input  wire logic signed [sus_pkg::VALUE_W-1:0] prev_value,
   input  wire logic                               prev_gt,
   input  wire logic signed [sus_pkg::VALUE_W-1:0] next_value,
   output      logic signed [sus_pkg::VALUE_W-1:0] value,
   output      logic                               gt,
   output      logic                               eq
);

   logic signed [sus_pkg::VALUE_W-1:0] value_ff;
   logic signed [sus_pkg::VALUE_W-1:0] value_in;

   // compare held value against the incoming one
   assign gt    = occupied && (value_ff > ctrl.value);
   assign eq    = occupied && (value_ff == ctrl.value);
   assign value = value_ff;

   // shift toward the head on drain; on insert, open a slot above the new value
   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = next_value;
      end else if (ctrl.insert && (gt || tail)) begin
         value_in = prev_gt ? prev_value : ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

/* sv/sorted_union_without_duplicates.sv */
// Top level of the sorted union block: load controller, counters and the
// chain of sus_cell storage cells. Depends on sus_pkg and sus_cell.
//
// Usage:
//   Items enter on the req_ channel (valid/ready), one per cycle while
//   loading. A first-list item is kept without a duplicate check; a second-list item is kept
//   only if no equal value is already held. Each list takes at most
//   LIST_DEPTH items; further ones are dropped and raise rsp_overflow.
//   The chain of 2*LIST_DEPTH cells compares and inserts as each item is
//   accepted, so loading runs at one item per cycle.
//   When an item with req_final_req is accepted and values are held, the
//   block stops taking items and drains: the first result appears the next
//   cycle, then one result per cycle while rsp_ready is high, in ascending
//   order, with rsp_last on the final one. The next item is taken in the
//   cycle after the last result. If no value is held, the run just clears.
//   While the receiver stalls, the head result holds and the chain waits.
//   After the drain all counts and the overflow flag return to zero.
//   Reset (synchronous, active high) empties the store at once.
`default_nettype none

module sorted_union_without_duplicates #(
   parameter int LIST_DEPTH = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic signed [sus_pkg::VALUE_W-1:0] req_value,
   input  wire logic                               req_second_list,
   input  wire logic                               req_final_req,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic signed [sus_pkg::VALUE_W-1:0] rsp_merged_value,
   output      logic                               rsp_last,
   output      logic                               rsp_overflow
);

   localparam int STORE_DEPTH = 2 * LIST_DEPTH;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int LST_W       = $clog2(LIST_DEPTH + 1);

   sus_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   kept_count_ff, kept_count_in;
   logic [LST_W-1:0]   first_count_ff, first_count_in;
   logic [LST_W-1:0]   second_count_ff, second_count_in;
   logic               dropped_ff, dropped_in;

   sus_pkg::cell_ctrl_type ctrl;

   logic signed [sus_pkg::VALUE_W-1:0] cell_value [STORE_DEPTH];
   logic signed [sus_pkg::VALUE_W-1:0] prev_value [STORE_DEPTH];
   logic signed [sus_pkg::VALUE_W-1:0] next_value [STORE_DEPTH];
   logic [STORE_DEPTH-1:0]             cell_gt;
   logic [STORE_DEPTH-1:0]             cell_eq;
   logic [STORE_DEPTH-1:0]             prev_gt;
   logic [STORE_DEPTH-1:0]             occupied;
   logic [STORE_DEPTH-1:0]             tail;

   logic req_fire, rsp_fire;
   logic first_full, second_full, duplicate, do_insert, store_full;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign first_full  = (first_count_ff == LST_W'(LIST_DEPTH));
   assign second_full = (second_count_ff == LST_W'(LIST_DEPTH));
   assign store_full  = (kept_count_ff == CNT_W'(STORE_DEPTH));
   assign duplicate   = |cell_eq;

   // decide whether the accepted item enters the store
   always_comb begin
      do_insert = 1'b0;
      if (req_fire && !store_full) begin
         if (req_second_list) begin
            do_insert = !second_full && !duplicate;
         end else begin
            do_insert = !first_full;
         end
      end
   end

   // broadcast controls to the chain
   always_comb begin
      ctrl.insert = do_insert;
      ctrl.shift  = rsp_fire;
      ctrl.value  = req_value;
   end

   // build the chain with neighbor links
   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      assign occupied[i] = (kept_count_ff > CNT_W'(i));
      assign tail[i]     = (kept_count_ff == CNT_W'(i));
      if (i == 0) begin : g_head
         assign prev_value[i] = req_value;
         assign prev_gt[i]    = 1'b0;
      end else begin : g_body
         assign prev_value[i] = cell_value[i-1];
         assign prev_gt[i]    = cell_gt[i-1];
      end
      if (i == STORE_DEPTH - 1) begin : g_end
         assign next_value[i] = cell_value[i];
      end else begin : g_mid
         assign next_value[i] = cell_value[i+1];
      end

      sus_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied[i]),
         .tail       (tail[i]),
         .prev_value (prev_value[i]),
         .prev_gt    (prev_gt[i]),
         .next_value (next_value[i]),
         .value      (cell_value[i]),
         .gt         (cell_gt[i]),
         .eq         (cell_eq[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sus_pkg::ST_LOAD: begin
            if (req_fire && req_final_req && (kept_count_in != '0)) begin
               state_in = sus_pkg::ST_DRAIN;
            end
         end
         sus_pkg::ST_DRAIN: begin
            if (rsp_fire && (kept_count_ff == CNT_W'(1))) begin
               state_in = sus_pkg::ST_LOAD;
            end
         end
         default: state_in = sus_pkg::ST_LOAD;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         sus_pkg::ST_LOAD:  req_ready = 1'b1;
         sus_pkg::ST_DRAIN: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   // result payload comes from the head cell
   assign rsp_merged_value = cell_value[0];
   assign rsp_last         = (kept_count_ff == CNT_W'(1));
   assign rsp_overflow     = dropped_ff;

   // advance counters and the drop flag
   always_comb begin
      kept_count_in   = kept_count_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      if (req_fire) begin
         if (req_second_list) begin
            if (second_full) begin
               dropped_in = 1'b1;
            end else begin
               second_count_in = second_count_ff + LST_W'(1);
            end
         end else begin
            if (first_full) begin
               dropped_in = 1'b1;
            end else begin
               first_count_in = first_count_ff + LST_W'(1);
            end
         end
         if (do_insert) begin
            kept_count_in = kept_count_ff + CNT_W'(1);
         end
         // a final item that leaves nothing stored just clears the run
         if (req_final_req && (kept_count_in == '0)) begin
            first_count_in  = '0;
            second_count_in = '0;
            dropped_in      = 1'b0;
         end
      end
      if (rsp_fire) begin
         kept_count_in = kept_count_ff - CNT_W'(1);
         if (kept_count_ff == CNT_W'(1)) begin
            first_count_in  = '0;
            second_count_in = '0;
            dropped_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= sus_pkg::ST_LOAD;
         kept_count_ff   <= '0;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         kept_count_ff   <= kept_count_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
      end
   end

`ifndef SYNTH
   // a result is only offered while values are held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (kept_count_ff != '0))
      else $error("result offered with empty store");

   // kept values never outnumber the items counted in while loading
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> ((CNT_W+1)'(kept_count_ff) <=
                     (CNT_W+1)'(first_count_ff) + (CNT_W+1)'(second_count_ff)))
      else $error("kept count exceeds items counted");

   // after the last result the block returns to loading with an empty store
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (req_ready && (kept_count_ff == '0)))
      else $error("store not empty after last result");
`endif

endmodule

`default_nettype wire
